[design/srg_pkg.sv]
// ----------------------------------------------------------------------------
// srg_pkg
// Types, constants and sequencer states shared by the subtractive random
// number generator and its subtractor sub-block (srg_subwrap).
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int WORD_W    = 30;
  localparam int SEED_W    = 28;
  localparam int ADDR_W    = 6;
  localparam int TAB_DEPTH = 56;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SEED_W-1:0] seed_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Modulus of every word and the fixed seeding constant
  localparam word_t MODULUS   = 30'd1000000000;
  localparam seed_t MSEED     = 28'd161803398;

  // Lag table geometry
  localparam addr_t LAG_LEN   = 6'd55;
  localparam addr_t FAR_START = 6'd31;
  localparam addr_t SPREAD    = 6'd21;
  // Mixing partner of entry i is 1 + (i + 30) mod 55
  localparam addr_t MIX_SPLIT = 6'd24;
  localparam addr_t MIX_UP    = 6'd31;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_INIT    = 9'b000000010,
    ST_SCATTER = 9'b000000100,
    ST_MIX_A   = 9'b000001000,
    ST_MIX_B   = 9'b000010000,
    ST_MIX_W   = 9'b000100000,
    ST_GEN_A   = 9'b001000000,
    ST_GEN_B   = 9'b010000000,
    ST_GEN_W   = 9'b100000000
  } state_t;

endpackage

[design/srg_ram.sv]
// ----------------------------------------------------------------------------
// srg_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srg_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 56
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/srg_subwrap.sv]
// ----------------------------------------------------------------------------
// srg_subwrap
// Shared modular subtractor: (a - b) wrapped into 0..999999999.
// ----------------------------------------------------------------------------
module srg_subwrap (
  input  srg_pkg::word_t a,
  input  srg_pkg::word_t b,
  output srg_pkg::word_t diff
);
  import srg_pkg::*;

  word_t plain;
  word_t wrapped;

  // Both forms computed, borrow picks one; the true result always fits in
  // 30 bits, so arithmetic modulo 2^30 gives it exactly
  assign plain   = a - b;
  assign wrapped = a + MODULUS - b;
  assign diff    = (a >= b) ? plain : wrapped;

endmodule

[design/subtractive_random_generator.sv]
// ----------------------------------------------------------------------------
// subtractive_random_generator
// Lagged subtractive random number generator returning integers 0..999999999.
//
// Usage:
//   Requests come on start/request and are taken at an edge where start is
//   high and busy is low. A word with request low is taken and does nothing.
//   Each result appears on random_value for one cycle with done high; the
//   receiver cannot stall, so it must take the word in that cycle.
//   The user writes the seed register through seed_we/seed only while the
//   block idles (not enforced); a write re-arms seeding for the next request.
// Timing:
//   Once seeded, a request passes ST_GEN_A, ST_GEN_B and ST_GEN_W before
//   done, and busy drops in the done cycle. This is set by the single read
//   port of the lag table: two reads and one write per word.
//   The first request after reset or a seed write first seeds the table:
//   entry 55 is written at init, the other 54 entries are scattered, and 4
//   mixing passes then rewrite all 55 entries, through the same subtractor.
// Reset:
//   rst is synchronous; it clears the seed to 0, marks the table unseeded
//   and sets the near and far pointers to 0 and 31.
// ----------------------------------------------------------------------------
module subtractive_random_generator (
  input  logic           clk,
  input  logic           rst,
  input  logic           seed_we,
  input  srg_pkg::seed_t seed,
  input  logic           start,
  input  logic           request,
  output logic           busy,
  output logic           done,
  output srg_pkg::word_t random_value
);
  import srg_pkg::*;

  state_t      state;
  seed_t       seed_reg;
  logic        seeded;
  addr_t       near_ptr;
  addr_t       far_ptr;
  addr_t       idx;
  addr_t       cnt;
  logic [1:0]  pass;
  word_t       prev;
  word_t       cur;
  word_t       hold;

  logic        ram_we;
  addr_t       ram_waddr;
  word_t       ram_wdata;
  addr_t       ram_raddr;
  word_t       ram_rdata;

  word_t       sub_a;
  word_t       sub_b;
  word_t       sub_diff;

  word_t       start_val;
  addr_t       mix_partner;
  addr_t       near_next;
  addr_t       far_next;
  logic [ADDR_W:0] idx_sum;
  addr_t       idx_next;
  logic        accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Seeding start value |MSEED - seed|, always below the modulus
  assign start_val = (seed_reg <= MSEED) ? {2'b00, MSEED - seed_reg}
                                         : {2'b00, seed_reg - MSEED};

  // Scatter index steps by 21 modulo 55
  assign idx_sum  = {1'b0, idx} + {1'b0, SPREAD};
  assign idx_next = (idx_sum >= {1'b0, LAG_LEN}) ? ADDR_W'(idx_sum - {1'b0, LAG_LEN})
                                                 : idx_sum[ADDR_W-1:0];

  // Mixing partner of entry cnt
  assign mix_partner = (cnt <= MIX_SPLIT) ? cnt + MIX_UP : cnt - MIX_SPLIT;

  // Pointers step cyclically over 1..55
  assign near_next = (near_ptr >= LAG_LEN) ? 6'd1 : near_ptr + 6'd1;
  assign far_next  = (far_ptr >= LAG_LEN) ? 6'd1 : far_ptr + 6'd1;

  // Operand selection for the shared subtractor
  assign sub_a = (state == ST_SCATTER) ? prev : hold;
  assign sub_b = (state == ST_SCATTER) ? cur  : ram_rdata;

  srg_subwrap u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff)
  );

  // Lag table port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = sub_diff;
    ram_raddr = cnt;
    case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = LAG_LEN;
        ram_wdata = start_val;
      end
      ST_SCATTER: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = cur;
      end
      ST_MIX_A: ram_raddr = cnt;
      ST_MIX_B: ram_raddr = mix_partner;
      ST_MIX_W: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
      end
      ST_GEN_A: ram_raddr = near_next;
      ST_GEN_B: ram_raddr = far_ptr;
      ST_GEN_W: begin
        ram_we    = 1'b1;
        ram_waddr = near_ptr;
      end
      default: ram_we = 1'b0;
    endcase
  end

  srg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TAB_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seed_reg <= '0;
      seeded   <= 1'b0;
      near_ptr <= '0;
      far_ptr  <= FAR_START;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (seed_we) begin
        seed_reg <= seed;
        seeded   <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && request) begin
            state <= seeded ? ST_GEN_A : ST_INIT;
          end
        end
        ST_INIT: begin
          state <= ST_SCATTER;
        end
        ST_SCATTER: begin
          if (cnt == LAG_LEN - 6'd1) begin
            state <= ST_MIX_A;
          end
        end
        ST_MIX_A: state <= ST_MIX_B;
        ST_MIX_B: state <= ST_MIX_W;
        ST_MIX_W: begin
          if (cnt == LAG_LEN && pass == 2'd3) begin
            seeded   <= 1'b1;
            near_ptr <= '0;
            far_ptr  <= FAR_START;
            state    <= ST_GEN_A;
          end else begin
            state <= ST_MIX_A;
          end
        end
        ST_GEN_A: begin
          near_ptr <= near_next;
          far_ptr  <= far_next;
          state    <= ST_GEN_B;
        end
        ST_GEN_B: state <= ST_GEN_W;
        ST_GEN_W: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_INIT: begin
        prev <= start_val;
        cur  <= 30'd1;
        cnt  <= 6'd1;
        idx  <= SPREAD;
      end
      ST_SCATTER: begin
        cur  <= sub_diff;
        prev <= cur;
        idx  <= idx_next;
        cnt  <= (cnt == LAG_LEN - 6'd1) ? 6'd1 : cnt + 6'd1;
        pass <= 2'd0;
      end
      ST_MIX_B: hold <= ram_rdata;
      ST_MIX_W: begin
        if (cnt == LAG_LEN) begin
          cnt  <= 6'd1;
          pass <= pass + 2'd1;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
      ST_GEN_B: hold <= ram_rdata;
      ST_GEN_W: random_value <= sub_diff;
      default: hold <= hold;
    endcase
  end

endmodule
